// ===== hdl/wpsf_pkg.sv =====
// ----------------------------------------------------------------------------
// wpsf_pkg
// Types, constants and helper functions of the 16-bit PCM WAV stream framer.
// ----------------------------------------------------------------------------
`default_nettype none

package wpsf_pkg;

   // header geometry
   localparam int HDR_BYTES = 44;
   localparam logic [5:0] HDR_LAST = 6'(HDR_BYTES - 1);

   // chunk tags, packed so that byte k of the file is bits [8k+7:8k]
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] RIFF_BASE   = 32'd36;
   localparam logic [31:0] FMT_SIZE    = 32'd16;
   localparam logic [15:0] FMT_PCM     = 16'd1;
   localparam logic [15:0] SAMPLE_BITS = 16'd16;

   // conversion constants
   localparam int          FRAC_BITS  = 20;
   localparam logic [20:0] Q_ONE      = 21'h10_0000;
   localparam logic [14:0] FULL_SCALE = 15'd32767;

   // register reset values
   localparam logic [19:0] RATE_RST  = 20'd48000;
   localparam logic [5:0]  CHAN_RST  = 6'd1;
   localparam logic [29:0] COUNT_RST = 30'd1;

   // register indexes
   typedef enum logic [1:0] {
      CSR_MODE        = 2'd0,
      CSR_SAMPLE_RATE = 2'd1,
      CSR_CHANNELS    = 2'd2,
      CSR_ITEM_COUNT  = 2'd3
   } csr_index_type;

   // operating mode
   localparam logic MODE_CONVERT = 1'b0;
   localparam logic MODE_RAW     = 1'b1;

   // live settings used by the byte emitter
   typedef struct packed {
      logic        mode;
      logic [29:0] item_count;
   } cfg_type;

   // header fields, precomputed from the settings
   typedef struct packed {
      logic [31:0] riff_size;
      logic [15:0] channels;
      logic [31:0] rate;
      logic [31:0] byte_rate;
      logic [15:0] align;
      logic [31:0] data_size;
   } hdr_fields_type;

   // item held in the input stage, already converted
   typedef struct packed {
      logic [15:0] pcm;
      logic [7:0]  raw_byte;
   } itm_type;

   // clamp a Q4.20 sample to +/-1, scale by 32767, truncate toward zero
   function automatic logic [15:0] convert_sample(input logic signed [23:0] s);
      logic        neg;
      logic [23:0] abs_val;
      logic [20:0] mag;
      logic [35:0] prod;
      logic [15:0] q;
      neg     = s[23];
      abs_val = neg ? (24'd0 - 24'(s)) : 24'(s);
      mag     = (abs_val > 24'(Q_ONE)) ? Q_ONE : abs_val[20:0];
      prod    = 36'(mag) * 36'(FULL_SCALE);
      q       = {1'b0, prod[FRAC_BITS +: 15]};
      return neg ? (16'd0 - q) : q;
   endfunction

   // one byte of the 44-byte header
   function automatic logic [7:0] hdr_byte(input logic [5:0] idx,
                                           input hdr_fields_type f);
      logic [31:0] w;
      unique case (idx[5:2])
         4'd0:    w = TAG_RIFF;
         4'd1:    w = f.riff_size;
         4'd2:    w = TAG_WAVE;
         4'd3:    w = TAG_FMT;
         4'd4:    w = FMT_SIZE;
         4'd5:    w = {f.channels, FMT_PCM};
         4'd6:    w = f.rate;
         4'd7:    w = f.byte_rate;
         4'd8:    w = {SAMPLE_BITS, f.align};
         4'd9:    w = TAG_DATA;
         4'd10:   w = f.data_size;
         default: w = 32'd0;
      endcase
      return w[{idx[1:0], 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/wpsf_if.sv =====
// ----------------------------------------------------------------------------
// wpsf_if
// Valid/ready channels of the framer: input items, output bytes, registers.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpsf_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] sample;
   logic [7:0]         raw_byte;

   modport source (output valid, sample, raw_byte, input ready);
   modport sink   (input valid, sample, raw_byte, output ready);
endinterface

interface wpsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, out_byte, last, input ready);
   modport sink   (input valid, out_byte, last, output ready);
endinterface

interface wpsf_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [29:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/wav_pcm16_stream_framer_top.sv =====
// ----------------------------------------------------------------------------
// wav_pcm16_stream_framer_top
// Turns audio items into the byte stream of a 16-bit PCM RIFF/WAV file.
//
// req_chan takes one item per handshake: a Q4.20 sample (convert mode) or
// a raw PCM byte (raw mode). rsp_chan gives one file byte per handshake,
// with last set on the final byte of each file. csr_chan writes the mode,
// sample rate, channel count and item count; it is always ready and is to be
// written only while no item is in flight; the block itself does not enforce this.
// Before the first item of each file the 44 header bytes go out. An item
// accepted on req_chan is held in the input register, moves on to the work
// register and its bytes go out through the output register to rsp_chan.
// While rsp_chan is ready the output port moves one byte per cycle; a
// convert-mode item has two bytes, a raw-mode item one, a file header 44.
// The input register takes the next item while the current one is being
// emitted, so items follow each other without gaps at that rate.
// A stall on rsp_chan holds the output byte and, once the input register
// is full, deasserts req_chan.ready. Reset clears the registers to 48 kHz,
// one channel, one item per file, convert mode, and starts a new file.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_pcm16_stream_framer_top (
   input  wire        clock,
   input  wire        reset,
   wpsf_req_if.sink   req_chan,
   wpsf_rsp_if.source rsp_chan,
   wpsf_csr_if.sink   csr_chan
);

   wpsf_pkg::cfg_type        cfg;
   wpsf_pkg::hdr_fields_type hdr;
   wpsf_pkg::itm_type        itm;
   logic                     itm_valid;
   logic                     itm_take;

   // configuration registers and header fields
   wpsf_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg),
      .hdr      (hdr)
   );

   // input register and sample conversion
   wpsf_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .itm_take  (itm_take),
      .itm_valid (itm_valid),
      .itm       (itm)
   );

   // header and data byte sequencer
   wpsf_emitter u_emit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .hdr       (hdr),
      .itm_valid (itm_valid),
      .itm       (itm),
      .itm_take  (itm_take),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== hdl/wpsf_csr_regs.sv =====
// ----------------------------------------------------------------------------
// wpsf_csr_regs
// Configuration registers and the registered header fields derived from them.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsf_csr_regs (
   input  wire                      clock,
   input  wire                      reset,
   wpsf_csr_if.sink                 csr_chan,
   output wpsf_pkg::cfg_type        cfg,
   output wpsf_pkg::hdr_fields_type hdr
);

   logic        mode_ff;
   logic [19:0] rate_ff;
   logic [5:0]  chan_ff;
   logic [29:0] count_ff;

   wpsf_pkg::hdr_fields_type hdr_ff, hdr_in;

   logic [15:0] ch;
   logic [30:0] data_size;
   logic [26:0] byte_rate;

   assign csr_chan.ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= wpsf_pkg::MODE_CONVERT;
         rate_ff  <= wpsf_pkg::RATE_RST;
         chan_ff  <= wpsf_pkg::CHAN_RST;
         count_ff <= wpsf_pkg::COUNT_RST;
      end else if (csr_chan.valid) begin
         unique case (wpsf_pkg::csr_index_type'(csr_chan.index))
            wpsf_pkg::CSR_MODE:        mode_ff  <= csr_chan.data[0];
            wpsf_pkg::CSR_SAMPLE_RATE: rate_ff  <= csr_chan.data[19:0];
            wpsf_pkg::CSR_CHANNELS:    chan_ff  <= csr_chan.data[5:0];
            wpsf_pkg::CSR_ITEM_COUNT:  count_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // header fields: convert mode always declares one channel
   always_comb begin
      ch        = (mode_ff == wpsf_pkg::MODE_RAW) ? 16'(chan_ff) : 16'd1;
      data_size = (mode_ff == wpsf_pkg::MODE_RAW) ? 31'(count_ff) : {count_ff, 1'b0};
      byte_rate = 27'(rate_ff) * 27'(ch[5:0]);

      hdr_in.riff_size = wpsf_pkg::RIFF_BASE + 32'(data_size);
      hdr_in.channels  = ch;
      hdr_in.rate      = 32'(rate_ff);
      hdr_in.byte_rate = {4'd0, byte_rate, 1'b0};
      hdr_in.align     = {ch[14:0], 1'b0};
      hdr_in.data_size = 32'(data_size);
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   assign hdr            = hdr_ff;
   assign cfg.mode       = mode_ff;
   assign cfg.item_count = count_ff;

endmodule

`default_nettype wire

// ===== hdl/wpsf_in_stage.sv =====
// ----------------------------------------------------------------------------
// wpsf_in_stage
// One-deep input register; presents the held item with its sample converted.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsf_in_stage (
   input  wire               clock,
   input  wire               reset,
   wpsf_req_if.sink          req_chan,
   input  wire               itm_take,
   output logic              itm_valid,
   output wpsf_pkg::itm_type itm
);

   logic               vld_ff;
   logic signed [23:0] sample_ff;
   logic [7:0]         raw_ff;
   logic               accept;

   // room when empty or when the held item leaves this cycle
   assign req_chan.ready = !vld_ff || itm_take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (accept) begin
         vld_ff <= 1'b1;
      end else if (itm_take) begin
         vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_chan.sample;
         raw_ff    <= req_chan.raw_byte;
      end
   end

   // clamp and scale
   assign itm_valid    = vld_ff;
   assign itm.pcm      = wpsf_pkg::convert_sample(sample_ff);
   assign itm.raw_byte = raw_ff;

endmodule

`default_nettype wire

// ===== hdl/wpsf_emitter.sv =====
// ----------------------------------------------------------------------------
// wpsf_emitter
// Work register, file bookkeeping and byte sequencer with the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsf_emitter (
   input  wire                      clock,
   input  wire                      reset,
   input  wpsf_pkg::cfg_type        cfg,
   input  wpsf_pkg::hdr_fields_type hdr,
   input  wire                      itm_valid,
   input  wpsf_pkg::itm_type        itm,
   output logic                     itm_take,
   wpsf_rsp_if.source               rsp_chan
);

   // file state
   logic        hdr_sent_ff;
   logic [29:0] done_cnt_ff;

   // work register
   logic        wrk_vld_ff;
   logic        wrk_hdr_ff;
   logic        wrk_sec_ff;
   logic        wrk_raw_ff;
   logic        wrk_last_ff;
   logic [7:0]  wrk_lo_ff;
   logic [7:0]  wrk_hi_ff;
   logic [5:0]  pos_ff;

   // output register
   logic        rsp_vld_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;

   logic        out_free;
   logic        emit;
   logic        fin;
   logic [7:0]  byte_in;
   logic        last_in;
   logic [29:0] cnt_next;
   logic        is_last;

   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign emit     = wrk_vld_ff && out_free;

   // pick the next byte of the current item
   always_comb begin
      if (wrk_hdr_ff) begin
         byte_in = wpsf_pkg::hdr_byte(pos_ff, hdr);
         last_in = 1'b0;
         fin     = 1'b0;
      end else if (!wrk_sec_ff) begin
         byte_in = wrk_lo_ff;
         last_in = wrk_raw_ff && wrk_last_ff;
         fin     = wrk_raw_ff;
      end else begin
         byte_in = wrk_hi_ff;
         last_in = wrk_last_ff;
         fin     = 1'b1;
      end
   end

   assign itm_take = itm_valid && (!wrk_vld_ff || (emit && fin));

   // item count and end of file
   assign cnt_next = done_cnt_ff + 30'd1;
   assign is_last  = (cnt_next >= cfg.item_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_sent_ff <= 1'b0;
         done_cnt_ff <= 30'd0;
      end else if (itm_take) begin
         hdr_sent_ff <= !is_last;
         done_cnt_ff <= is_last ? 30'd0 : cnt_next;
      end
   end

   // work register sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         wrk_vld_ff <= 1'b0;
         wrk_hdr_ff <= 1'b0;
         wrk_sec_ff <= 1'b0;
         pos_ff     <= 6'd0;
      end else if (itm_take) begin
         wrk_vld_ff <= 1'b1;
         wrk_hdr_ff <= !hdr_sent_ff;
         wrk_sec_ff <= 1'b0;
         pos_ff     <= 6'd0;
      end else if (emit) begin
         if (wrk_hdr_ff) begin
            if (pos_ff == wpsf_pkg::HDR_LAST) begin
               wrk_hdr_ff <= 1'b0;
               pos_ff     <= 6'd0;
            end else begin
               pos_ff <= pos_ff + 6'd1;
            end
         end else if (fin) begin
            wrk_vld_ff <= 1'b0;
         end else begin
            wrk_sec_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (itm_take) begin
         wrk_raw_ff  <= (cfg.mode == wpsf_pkg::MODE_RAW);
         wrk_last_ff <= is_last;
         wrk_lo_ff   <= (cfg.mode == wpsf_pkg::MODE_RAW) ? itm.raw_byte : itm.pcm[7:0];
         wrk_hi_ff   <= itm.pcm[15:8];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= byte_in;
         rsp_last_ff <= last_in;
      end
   end

   assign rsp_chan.valid    = rsp_vld_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.last     = rsp_last_ff;

endmodule

`default_nettype wire

// ===== verif/tb_wav_pcm16_stream_framer_top.sv =====
// ----------------------------------------------------------------------------
// tb_wav_pcm16_stream_framer_top
// Self-checking testbench of the 16-bit PCM WAV stream framer.
//
// Items go in on req_chan and file bytes are collected from rsp_chan under
// random idling on both sides. A scoreboard class keeps its own copy of the
// registers and the file position. It builds the header of a new file and
// the converted or raw data bytes of every accepted item, and checks each
// output byte and its last flag in order. Register writes happen between
// phases once the byte stream has drained. Some phases end in the middle of
// a file, so settings change while a file is open.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wav_pcm16_stream_framer_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF       = 6;
   localparam int RESET_CYCLES   = 6;
   localparam int IDLE_PERCENT   = 28;
   localparam int RANDOM_ITEMS   = 80;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_PRINTS     = 40;

   // wav format constants
   localparam int          Q_FRAC          = 20;
   localparam int          Q_UNITY         = 1 << Q_FRAC;
   localparam longint      PCM_FULL_SCALE  = 32767;
   localparam logic [31:0] RIFF_OVERHEAD   = 32'd36;
   localparam logic [31:0] FMT_CHUNK_BYTES = 32'd16;
   localparam logic [31:0] WAVE_FORMAT_PCM = 32'd1;
   localparam logic [31:0] BITS_PER_SAMPLE = 32'd16;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } wav_byte_type;

   // expected file bytes, built from the registers and the file position
   class wav_byte_checker;
      logic         mode;
      logic [19:0]  rate;
      logic [5:0]   chans;
      logic [29:0]  count;
      bit           header_sent;
      logic [29:0]  items_done;
      wav_byte_type pending_bytes[$];
      int           mismatches;

      function new();
         mode        = wpsf_pkg::MODE_CONVERT;
         rate        = 20'd48000;
         chans       = 6'd1;
         count       = 30'd1;
         header_sent = 1'b0;
         items_done  = '0;
         mismatches  = 0;
      endfunction

      function int pending();
         return pending_bytes.size();
      endfunction

      function void set_reg(wpsf_pkg::csr_index_type idx, logic [29:0] d);
         case (idx)
            wpsf_pkg::CSR_MODE:        mode  = d[0];
            wpsf_pkg::CSR_SAMPLE_RATE: rate  = d[19:0];
            wpsf_pkg::CSR_CHANNELS:    chans = d[5:0];
            wpsf_pkg::CSR_ITEM_COUNT:  count = d;
            default: ;
         endcase
      endfunction

      // append one expected byte at the tail
      function void add_byte(logic [7:0] v, logic l);
         wav_byte_type w;
         w.value = v;
         w.last  = l;
         pending_bytes = {pending_bytes, w};
      endfunction

      function void push_le(logic [31:0] v, int n);
         for (int i = 0; i < n; i++) add_byte(v[8*i +: 8], 1'b0);
      endfunction

      function void push_tag(string t);
         for (int i = 0; i < 4; i++) add_byte(t[i], 1'b0);
      endfunction

      // clamp to +/-1, scale by full scale, truncate toward zero
      function logic [15:0] pcm16(logic signed [23:0] s);
         int          v;
         longint      scaled;
         logic [15:0] q;
         v = s;
         if (v > Q_UNITY) v = Q_UNITY;
         if (v < -Q_UNITY) v = -Q_UNITY;
         scaled = (longint'(v < 0 ? -v : v) * PCM_FULL_SCALE) >>> Q_FRAC;
         q = 16'(scaled);
         return (v < 0) ? 16'd0 - q : q;
      endfunction

      function void build_header();
         logic [31:0] ch;
         logic [31:0] data_bytes;
         ch         = (mode == wpsf_pkg::MODE_RAW) ? 32'(chans) : 32'd1;
         data_bytes = (mode == wpsf_pkg::MODE_RAW) ? 32'(count) : {1'b0, count, 1'b0};
         push_tag("RIFF");
         push_le(RIFF_OVERHEAD + data_bytes, 4);
         push_tag("WAVE");
         push_tag("fmt ");
         push_le(FMT_CHUNK_BYTES, 4);
         push_le(WAVE_FORMAT_PCM, 2);
         push_le(ch, 2);
         push_le(32'(rate), 4);
         push_le(32'(rate) * ch * 32'd2, 4);
         push_le(ch * 32'd2, 2);
         push_le(BITS_PER_SAMPLE, 2);
         push_tag("data");
         push_le(data_bytes, 4);
      endfunction

      // accepted input item: header on a new file, then its data bytes
      function void note_item(logic signed [23:0] s, logic [7:0] rb);
         logic        at_end;
         logic [15:0] pcm;
         if (!header_sent) begin
            build_header();
            header_sent = 1'b1;
         end
         items_done = items_done + 30'd1;
         at_end     = (items_done >= count);
         if (mode == wpsf_pkg::MODE_CONVERT) begin
            pcm = pcm16(s);
            add_byte(pcm[7:0], 1'b0);
            add_byte(pcm[15:8], at_end);
         end else begin
            add_byte(rb, at_end);
         end
         if (at_end) begin
            items_done  = '0;
            header_sent = 1'b0;
         end
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= MAX_PRINTS) $display("%0t mismatch: %s", $realtime, what);
      endtask

      task check_byte(logic [7:0] b, logic l);
         wav_byte_type w;
         if (pending_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h last %0b", b, l));
            return;
         end
         w = pending_bytes.pop_front();
         if (b !== w.value) report($sformatf("out_byte %02h, expected %02h", b, w.value));
         if (l !== w.last) report($sformatf("last %0b, expected %0b", l, w.last));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   idle_cycles;
   int   rand_items;
   wav_byte_checker sb;

   logic signed [23:0] corner_samples[10] = '{
      24'h000000, 24'h000001, 24'hFFFFFF, 24'h0FFFFF, 24'h100000,
      24'h100001, 24'hF00000, 24'hEFFFFF, 24'h7FFFFF, 24'h800000
   };

   wpsf_req_if req_chan ();
   wpsf_rsp_if rsp_chan ();
   wpsf_csr_if csr_chan ();

   wav_pcm16_stream_framer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // output side backpressure
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (csr_chan.valid && csr_chan.ready) begin
            sb.set_reg(wpsf_pkg::csr_index_type'(csr_chan.index), csr_chan.data);
            idle_cycles = 0;
         end
         if (req_chan.valid && req_chan.ready) begin
            sb.note_item(req_chan.sample, req_chan.raw_byte);
            idle_cycles = 0;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_byte(rsp_chan.out_byte, rsp_chan.last);
            idle_cycles = 0;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // one item; valid stays high into the next item when there is no gap
   task automatic send_item(logic signed [23:0] s, logic [7:0] rb);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.sample   <= s;
      req_chan.raw_byte <= rb;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   task automatic write_reg(wpsf_pkg::csr_index_type idx, logic [29:0] d);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= d;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending, wait for the byte stream to drain, then let it settle
   task automatic finish_phase();
      req_chan.valid <= 1'b0;
      // let the monitor note the last accepted item first
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_sample();
      case ($urandom_range(0, 9))
         0, 1:    return 24'($urandom);
         2:       return corner_samples[$urandom_range(0, 9)];
         default: return 24'(int'($urandom_range(0, 2 * Q_UNITY)) - Q_UNITY);
      endcase
   endfunction

   // random settings, extremes and out-of-range values included
   task automatic randomize_config();
      logic [29:0] d;
      if ($urandom_range(0, 1)) begin
         d = ($urandom_range(0, 4) == 0) ? 30'($urandom) : 30'($urandom_range(0, 1));
         write_reg(wpsf_pkg::CSR_MODE, d);
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 5))
            0:       d = 30'd1;
            1:       d = 30'd1000000;
            2:       d = 30'd0;
            3:       d = 30'($urandom);
            default: d = 30'($urandom_range(8000, 192000));
         endcase
         write_reg(wpsf_pkg::CSR_SAMPLE_RATE, d);
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 6))
            0:       d = 30'd1;
            1:       d = 30'd32;
            2:       d = 30'd0;
            3:       d = 30'd63;
            4:       d = 30'($urandom);
            default: d = 30'($urandom_range(1, 32));
         endcase
         write_reg(wpsf_pkg::CSR_CHANNELS, d);
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0:       d = 30'd0;
            1:       d = 30'h3FFF_FFFF;
            2:       d = 30'($urandom);
            default: d = 30'($urandom_range(1, 6));
         endcase
         write_reg(wpsf_pkg::CSR_ITEM_COUNT, d);
      end
   endtask

   // stimulus
   initial begin
      int n;
      sb = new;
      calm = 1'b0;
      rand_items = 0;
      reset <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.sample   <= '0;
      req_chan.raw_byte <= '0;
      csr_chan.valid    <= 1'b0;
      csr_chan.index    <= wpsf_pkg::CSR_MODE;
      csr_chan.data     <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: convert mode, one item per file, sample corners
      foreach (corner_samples[i]) send_item(corner_samples[i], 8'($urandom));
      finish_phase();

      // raw mode at a rate of 1000000 and 32 channels, three items per file
      write_reg(wpsf_pkg::CSR_MODE, 30'(wpsf_pkg::MODE_RAW));
      write_reg(wpsf_pkg::CSR_SAMPLE_RATE, 30'd1000000);
      write_reg(wpsf_pkg::CSR_CHANNELS, 30'd32);
      write_reg(wpsf_pkg::CSR_ITEM_COUNT, 30'd3);
      send_item('0, 8'h00);
      send_item('0, 8'hFF);
      send_item('0, 8'h55);
      send_item('0, 8'hAA);
      finish_phase();

      // zero item count, zero rate and zero channels
      write_reg(wpsf_pkg::CSR_ITEM_COUNT, 30'd0);
      write_reg(wpsf_pkg::CSR_SAMPLE_RATE, 30'd0);
      write_reg(wpsf_pkg::CSR_CHANNELS, 30'd0);
      send_item('0, 8'h3C);
      send_item('0, 8'hC3);
      finish_phase();

      // widest field values, file left open across the next phase
      write_reg(wpsf_pkg::CSR_MODE, 30'(wpsf_pkg::MODE_CONVERT));
      write_reg(wpsf_pkg::CSR_SAMPLE_RATE, 30'hF_FFFF);
      write_reg(wpsf_pkg::CSR_CHANNELS, 30'd63);
      write_reg(wpsf_pkg::CSR_ITEM_COUNT, 30'h3FFF_FFFF);
      send_item(24'h7FFFFF, 8'h00);
      send_item(24'h800000, 8'hFF);
      finish_phase();

      // count lowered and mode switched mid-file: the next item closes it
      write_reg(wpsf_pkg::CSR_ITEM_COUNT, 30'd2);
      write_reg(wpsf_pkg::CSR_MODE, 30'(wpsf_pkg::MODE_RAW));
      send_item(24'h123456, 8'h81);
      send_item(24'h654321, 8'h7E);
      finish_phase();

      // random phases, with a stretch of no idling in the middle
      while (rand_items < RANDOM_ITEMS) begin
         calm = (rand_items >= 40 && rand_items < 65);
         randomize_config();
         n = $urandom_range(1, 12);
         repeat (n) begin
            send_item(rand_sample(), 8'($urandom));
            rand_items++;
         end
         finish_phase();
      end
      calm = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d bytes never came", sb.pending()));
      if (sb.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/wpsf_pkg.sv
hdl/wpsf_if.sv
hdl/wpsf_csr_regs.sv
hdl/wpsf_in_stage.sv
hdl/wpsf_emitter.sv
hdl/wav_pcm16_stream_framer_top.sv
verif/tb_wav_pcm16_stream_framer_top.sv
